// ===== sv/lset_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lset_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int ALPHA_SCALE  = 256;
	localparam int ALPHA_W      = $clog2(ALPHA_SCALE);

	localparam int WEIGHT_W  = 8;
	localparam int WEIGHTS_W = 64;
	localparam int LIMIT_W   = 15;
	localparam int GAIN_W    = 9;
	localparam int DBAND_W   = 8;
	localparam int ERR_W     = 16;
	localparam int RAW_W     = 8;
	localparam int STAT_W    = 3;
	localparam int LOST_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
	localparam int IDX_W  = $clog2(SENSOR_COUNT);
	localparam int SUM_W  = $clog2(SENSOR_COUNT * 128) + 1;
	localparam int DVD_W  = SUM_W;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam int MAG_W  = ERR_W + 1;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int ADJ_W  = PROD_W + 1 - ALPHA_W;
	localparam int FILT_W = ADJ_W + 2;

	localparam int MIN_STEP = 4;

	localparam logic [WEIGHTS_W-1:0] WEIGHTS_RST = 64'h3626180AF6E8DACA;
	localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 15'd80;
	localparam logic [GAIN_W-1:0]    GAIN_RST    = 9'd192;
	localparam logic [DBAND_W-1:0]   DBAND_RST   = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHTS = 2'd0,
		CFG_LIMIT   = 2'd1,
		CFG_GAIN    = 2'd2,
		CFG_DBAND   = 2'd3
	} cfg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_LOST_UNKNOWN = 3'd0,
		STAT_LOST_LEFT    = 3'd1,
		STAT_LOST_RIGHT   = 3'd2,
		STAT_TRACKING     = 3'd3,
		STAT_CROSS_LINE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_DSTART,
		S_DIV,
		S_MUL,
		S_FIN
	} state_t;

	// symmetric clamp to +-lim
	function automatic logic signed [ERR_W-1:0] clamp_err(
		input logic signed [FILT_W-1:0] v,
		input logic [LIMIT_W-1:0]       lim
	);
		logic signed [FILT_W-1:0] hi;
		logic signed [FILT_W-1:0] lo;
		logic signed [FILT_W-1:0] r;
		hi = signed'(FILT_W'(lim));
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[ERR_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/line_sensor_error_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A sample is accepted only in idle; the weight sweep, the bit-serial divider, the gain
// multiply and the final step then run in order before the result is registered. A sample
// with no sensor active skips the divider and the multiply. No new sample is taken until the
// previous one is through, and the final step stalls while an unread result is held.
// A new sample is taken as soon as the previous result is registered, even if not yet read.
// Reset (arst_n low, asynchronous): tracking state zero, registers at defaults, no result.
module line_sensor_error_tracker_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [lset_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lset_pkg::WEIGHTS_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        pin_bits,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [lset_pkg::ERR_W-1:0]      error_out,
	output logic signed [lset_pkg::RAW_W-1:0]      raw_out,
	output logic [lset_pkg::STAT_W-1:0]            status_out,
	output logic [lset_pkg::CNT_W-1:0]             active_out,
	output logic [lset_pkg::LOST_W-1:0]            lost_out
);
	import lset_pkg::*;

	// configuration
	logic [WEIGHTS_W-1:0] weights_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [DBAND_W-1:0]   dband_q;

	// tracking state
	logic signed [ERR_W-1:0] cur_q;
	logic signed [ERR_W-1:0] prev_q;
	logic signed [RAW_W-1:0] raw_q;
	logic [LOST_W-1:0]       lost_cnt_q;
	logic                    have_q;

	// per-sample work registers
	state_t                  state_q, state_d;
	logic [SENSOR_COUNT-1:0] pins_q;
	logic [IDX_W-1:0]        idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic signed [RAW_W-1:0] raw_new_q;
	logic                    dneg_q;
	logic [PROD_W-1:0]       prod_q;

	// output register
	logic                    out_valid_q;
	logic signed [ERR_W-1:0] err_out_q;
	logic signed [RAW_W-1:0] raw_out_q;
	status_t                 stat_out_q;
	logic [CNT_W-1:0]        act_out_q;
	logic [LOST_W-1:0]       lost_out_q;

	// control
	logic in_fire;
	logic div_start;
	logic commit;
	logic acc_last;

	// divider
	logic [DVD_W-1:0] dvd;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	// datapath
	logic [CNT_W-1:0]        pop;
	logic [WEIGHT_W-1:0]     wsel;
	logic [SUM_W-1:0]        sum_abs;
	logic signed [RAW_W-1:0] quo_raw;
	logic signed [MAG_W:0]   delta;
	logic [MAG_W-1:0]        delta_mag;
	logic [GAIN_W-1:0]       gain_eff;
	logic [ADJ_W-1:0]        adj;
	logic signed [FILT_W-1:0] cur_x;
	logic signed [FILT_W-1:0] filt;
	logic signed [FILT_W-1:0] step;
	logic signed [FILT_W-1:0] step_c;
	logic signed [FILT_W-1:0] rec;
	logic signed [FILT_W-1:0] cand;
	logic [ERR_W-1:0]        cur_mag;
	logic                    lost;
	logic                    unknown;
	status_t                 stat_new;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= WEIGHTS_RST;
			limit_q   <= LIMIT_RST;
			gain_q    <= GAIN_RST;
			dband_q   <= DBAND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WEIGHTS: weights_q <= cfg_data;
				CFG_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				CFG_GAIN:    gain_q    <= cfg_data[GAIN_W-1:0];
				CFG_DBAND:   dband_q   <= cfg_data[DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_fire) state_d = S_ACC;
			S_ACC:    if (acc_last) state_d = (cnt_q == '0) ? S_FIN : S_DSTART;
			S_DSTART: state_d = S_DIV;
			S_DIV:    if (div_done) state_d = S_MUL;
			S_MUL:    state_d = S_FIN;
			S_FIN:    if (commit) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			S_IDLE:   in_ready  = 1'b1;
			S_DSTART: div_start = 1'b1;
			S_FIN:    commit    = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_fire  = in_valid && in_ready;
	assign acc_last = idx_q == IDX_W'(SENSOR_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		pop = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			pop = pop + CNT_W'(pin_bits[i]);
		end
	end

	// accumulate one sensor weight per cycle
	assign wsel = weights_q[idx_q * WEIGHT_W +: WEIGHT_W];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pins_q <= pin_bits[SENSOR_COUNT-1:0];
			cnt_q  <= pop;
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (state_q == S_ACC) begin
			idx_q <= idx_q + 1'b1;
			if (pins_q[idx_q]) begin
				sum_q <= sum_q + signed'({{(SUM_W - WEIGHT_W){wsel[WEIGHT_W-1]}}, wsel});
			end
		end
	end

	// round half away from zero: divide |sum| + count/2 and restore the sign
	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dvd     = sum_abs + SUM_W'(cnt_q >> 1);

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= sum_q[SUM_W-1];
		end
	end

	lset_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_raw = neg_q ? -signed'(div_quo[RAW_W-1:0]) : signed'(div_quo[RAW_W-1:0]);

	always_comb begin
		if (gain_q == '0) begin
			gain_eff = GAIN_W'(1);
		end else if (gain_q > GAIN_W'(ALPHA_SCALE)) begin
			gain_eff = GAIN_W'(ALPHA_SCALE);
		end else begin
			gain_eff = gain_q;
		end
	end

	assign delta     = (MAG_W + 1)'(raw_new_q) - (MAG_W + 1)'(cur_q);
	assign delta_mag = delta[MAG_W] ? MAG_W'(-delta) : MAG_W'(delta);

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_done) begin
			raw_new_q <= quo_raw;
		end
		if (state_q == S_MUL) begin
			dneg_q <= delta[MAG_W];
			prod_q <= PROD_W'(delta_mag * gain_eff);
		end
	end

	// final step: filter, lost recovery or zero when the side is unknown, then the shared clamp
	always_comb begin
		lost    = cnt_q == '0;
		cur_x   = FILT_W'(cur_q);
		adj     = ADJ_W'((PROD_W + 1)'(prod_q) + (PROD_W + 1)'(ALPHA_SCALE / 2) >> ALPHA_W);
		if (have_q) begin
			filt = dneg_q ? cur_x - FILT_W'(adj) : cur_x + FILT_W'(adj);
		end else begin
			filt = FILT_W'(raw_new_q);
		end

		cur_mag = cur_q[ERR_W-1] ? ERR_W'(-cur_q) : ERR_W'(cur_q);
		unknown = !have_q || (cur_mag <= ERR_W'(dband_q));

		step = cur_x - FILT_W'(prev_q);
		if (cur_q[ERR_W-1]) begin
			step = -step;
		end
		step_c = step;
		if (step_c < FILT_W'(MIN_STEP)) begin
			step_c = FILT_W'(MIN_STEP);
		end
		if (step_c > signed'(FILT_W'(limit_q))) begin
			step_c = signed'(FILT_W'(limit_q));
		end
		rec = cur_q[ERR_W-1] ? cur_x - step_c : cur_x + step_c;

		if (!lost) begin
			cand     = filt;
			stat_new = (cnt_q == CNT_W'(SENSOR_COUNT)) ? STAT_CROSS_LINE : STAT_TRACKING;
		end else if (unknown) begin
			cand     = '0;
			stat_new = STAT_LOST_UNKNOWN;
		end else begin
			cand     = rec;
			stat_new = cur_q[ERR_W-1] ? STAT_LOST_LEFT : STAT_LOST_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			prev_q     <= '0;
			raw_q      <= '0;
			lost_cnt_q <= '0;
			have_q     <= 1'b0;
		end else if (commit) begin
			cur_q  <= clamp_err(cand, limit_q);
			prev_q <= cur_q;
			if (lost) begin
				if (lost_cnt_q != '1) begin
					lost_cnt_q <= lost_cnt_q + 1'b1;
				end
			end else begin
				lost_cnt_q <= '0;
				raw_q      <= raw_new_q;
				have_q     <= 1'b1;
			end
		end
	end

	// output register: hold the transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			err_out_q  <= clamp_err(cand, limit_q);
			raw_out_q  <= lost ? raw_q : raw_new_q;
			stat_out_q <= stat_new;
			act_out_q  <= cnt_q;
			lost_out_q <= lost ? ((lost_cnt_q != '1) ? lost_cnt_q + 1'b1 : lost_cnt_q) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign error_out  = err_out_q;
	assign raw_out    = raw_out_q;
	assign status_out = stat_out_q;
	assign active_out = act_out_q;
	assign lost_out   = lost_out_q;

	a_lost_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((active_out == '0) == (status_out == STAT_LOST_UNKNOWN
			|| status_out == STAT_LOST_LEFT || status_out == STAT_LOST_RIGHT)))
		else $error("status disagrees with active count");

	a_lost_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active_out != '0 |-> lost_out == '0)
		else $error("lost count not cleared on a line sample");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_out <= signed'(ERR_W'(limit_q))
			&& error_out >= -signed'(ERR_W'(limit_q))))
		else $error("error outside clamp bound");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

// ===== sv/lset_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lset_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lset_pkg::DVD_W-1:0] dividend,
	input  wire logic [lset_pkg::CNT_W-1:0] divisor,
	output logic                           done,
	output logic [lset_pkg::DVD_W-1:0]     quotient
);
	import lset_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dvs_q;

	logic [CNT_W:0]    trial;
	logic              fits;
	logic [CNT_W:0]    diff;

	// one restoring step per cycle while busy, quotient bits shift in behind the dividend
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire
